### sv/srd_pkg.sv
// ---------------------------------------------------------------------------
// srd_pkg
// Shared widths, constants and the square-root step for the radial deadzone.
// ---------------------------------------------------------------------------
package srd_pkg;

   localparam int AXIS_W = 16;   // raw and conditioned axis width
   localparam int MAG_W  = 15;   // unsigned magnitude width
   localparam int SQ_W   = 32;   // sum of squares, padded to an even width
   localparam int ROOT_W = 16;   // floor sqrt of SQ_W bits
   localparam int REM_W  = 19;   // sqrt partial remainder
   localparam int NUM_W  = 30;   // dividend width of both divisions
   localparam int QUO_W  = 15;   // quotient width of both divisions
   localparam int DEN_W  = 16;   // divisor width of both divisions

   localparam logic [MAG_W-1:0] FULL_SCALE = 15'd32767;
   localparam logic [MAG_W-1:0] DZ_MAX     = 15'd31128;
   localparam logic [MAG_W-1:0] DZ_RESET   = 15'd4915;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_acc_type;

   // One result bit of a restoring square root: two radicand bits in.
   function automatic sqrt_acc_type sqrt_step(sqrt_acc_type acc, logic [1:0] pair);
      logic [REM_W-1:0] r;
      logic [REM_W-1:0] t;
      sqrt_acc_type     o;
      r = {acc.rem[REM_W-3:0], pair};
      t = {1'b0, acc.root, 2'b01};
      if (r >= t) begin
         o.rem  = r - t;
         o.root = {acc.root[ROOT_W-2:0], 1'b1};
      end else begin
         o.rem  = r;
         o.root = {acc.root[ROOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

endpackage

### sv/srd_sqrt.sv
// ---------------------------------------------------------------------------
// srd_sqrt
// Pipelined floor square root, one root bit per stage, side word carried.
// ---------------------------------------------------------------------------
module srd_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [srd_pkg::SQ_W-1:0]   in_sq,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [srd_pkg::ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0]          out_side
);
   import srd_pkg::*;

   localparam int STEPS = ROOT_W;

   logic [STEPS-1:0]  v_ff;
   sqrt_acc_type      acc_ff  [STEPS];
   logic [SQ_W-1:0]   n_ff    [STEPS];
   logic [SIDE_W-1:0] side_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic              v_in;
      sqrt_acc_type      acc_in;
      logic [SQ_W-1:0]   n_in;
      logic [SIDE_W-1:0] side_in;
      if (k == 0) begin : g_first
         assign v_in    = in_valid;
         assign acc_in  = sqrt_step(sqrt_acc_type'('0), in_sq[SQ_W-1 -: 2]);
         assign n_in    = in_sq << 2;
         assign side_in = in_side;
      end else begin : g_next
         assign v_in    = v_ff[k-1];
         assign acc_in  = sqrt_step(acc_ff[k-1], n_ff[k-1][SQ_W-1 -: 2]);
         assign n_in    = n_ff[k-1] << 2;
         assign side_in = side_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_in;
         end
         acc_ff[k]  <= acc_in;
         n_ff[k]    <= n_in;
         side_ff[k] <= side_in;
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_root  = acc_ff[STEPS-1].root;
   assign out_side  = side_ff[STEPS-1];

endmodule

### sv/srd_div.sv
// ---------------------------------------------------------------------------
// srd_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit QUO_W bits, i.e. the dividend's upper part is below the divisor.
// ---------------------------------------------------------------------------
module srd_div #(
   parameter int SIDE_W = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [srd_pkg::NUM_W-1:0] in_num,
   input  logic [srd_pkg::DEN_W-1:0] in_den,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic [srd_pkg::QUO_W-1:0] out_quo,
   output logic [SIDE_W-1:0]         out_side
);
   import srd_pkg::*;

   localparam int STEPS = QUO_W;

   logic [STEPS-1:0]  v_ff;
   logic [DEN_W-1:0]  rem_ff  [STEPS];
   logic [QUO_W-1:0]  lo_ff   [STEPS];   // low dividend bits out, quotient bits in
   logic [DEN_W-1:0]  den_ff  [STEPS];
   logic [SIDE_W-1:0] side_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic              v_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [QUO_W-1:0]  lo_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              qbit;
      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = {1'b0, in_num[NUM_W-1:QUO_W]};
         assign lo_prev   = in_num[QUO_W-1:0];
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign lo_prev   = lo_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
      end
      assign trial = {rem_prev, lo_prev[QUO_W-1]};
      assign diff  = trial - {1'b0, den_prev};
      assign qbit  = (trial >= {1'b0, den_prev});
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_prev;
         end
         rem_ff[k]  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         lo_ff[k]   <= {lo_prev[QUO_W-2:0], qbit};
         den_ff[k]  <= den_prev;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_quo   = lo_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

### sv/stick_radial_deadzone.sv
// ---------------------------------------------------------------------------
// stick_radial_deadzone
// Radial deadzone conditioning of one X/Y analog stick sample.
// ---------------------------------------------------------------------------
// A sample is taken on any cycle with start high; busy is always low, so a new
// sample may follow every cycle. The result appears 51 cycles later on the
// rsp_ ports for one cycle, marked by rsp_valid, and must be captured then.
// The latency is set by the pipeline: 2 stages of clamp and squaring, 16 square
// root stages, 15 stages for the magnitude rescale division, 15 stages for the
// per-axis direction division, and 3 stages around them. The deadzone register
// may be written only while no sample is in flight; it reads back nothing and
// values above 31128 act as 31128.
// ---------------------------------------------------------------------------
module stick_radial_deadzone (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [srd_pkg::AXIS_W-1:0] req_raw_x,
   input  logic signed [srd_pkg::AXIS_W-1:0] req_raw_y,
   output logic                        rsp_valid,
   output logic signed [srd_pkg::AXIS_W-1:0] rsp_out_x,
   output logic signed [srd_pkg::AXIS_W-1:0] rsp_out_y,
   output logic                        rsp_in_deadzone,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [srd_pkg::MAG_W-1:0]   csr_stick_deadzone
);
   import srd_pkg::*;

   localparam int LATENCY = 2 + ROOT_W + 1 + QUO_W + 1 + QUO_W + 1;
   localparam int S_SIDE_W = 2 + 2 * MAG_W;
   localparam int M_SIDE_W = S_SIDE_W + ROOT_W + 2;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   logic [MAG_W-1:0] dz_ff;
   logic [MAG_W-1:0] dz_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= DZ_RESET;
      end else if (csr_valid && csr_ready) begin
         dz_ff <= csr_stick_deadzone;
      end
   end
   assign dz_eff = (dz_ff > DZ_MAX) ? DZ_MAX : dz_ff;

   // stage 1: clamp to +-32767, split into sign and magnitude
   logic             v1_ff;
   logic             sx1_ff, sy1_ff;
   logic [MAG_W-1:0] ax1_ff, ay1_ff;
   logic [AXIS_W-1:0] neg_x, neg_y;

   assign neg_x = -req_raw_x;
   assign neg_y = -req_raw_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      sx1_ff <= req_raw_x[AXIS_W-1];
      sy1_ff <= req_raw_y[AXIS_W-1];
      ax1_ff <= !req_raw_x[AXIS_W-1] ? req_raw_x[MAG_W-1:0] :
                neg_x[AXIS_W-1] ? FULL_SCALE : neg_x[MAG_W-1:0];
      ay1_ff <= !req_raw_y[AXIS_W-1] ? req_raw_y[MAG_W-1:0] :
                neg_y[AXIS_W-1] ? FULL_SCALE : neg_y[MAG_W-1:0];
   end

   // stage 2: sum of squares
   logic                v2_ff;
   logic [SQ_W-1:0]     sq2_ff;
   logic [S_SIDE_W-1:0] side2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      sq2_ff   <= SQ_W'(ax1_ff) * SQ_W'(ax1_ff) + SQ_W'(ay1_ff) * SQ_W'(ay1_ff);
      side2_ff <= {sx1_ff, sy1_ff, ax1_ff, ay1_ff};
   end

   logic                rv;
   logic [ROOT_W-1:0]   rlen;
   logic [S_SIDE_W-1:0] rside;

   srd_sqrt #(.SIDE_W(S_SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_sq     (sq2_ff),
      .in_side   (side2_ff),
      .out_valid (rv),
      .out_root  (rlen),
      .out_side  (rside)
   );

   // stage 3: deadzone test, saturation test, rescale dividend
   logic                v3_ff;
   logic [NUM_W-1:0]    num3_ff;
   logic [DEN_W-1:0]    den3_ff;
   logic [M_SIDE_W-1:0] side3_ff;
   logic                zero3;
   logic                sat3;
   logic [ROOT_W-1:0]   diff3;

   assign zero3 = (rlen == '0) || (rlen <= ROOT_W'(dz_eff));
   // (len-dz)/(FS-dz) reaches 1 exactly when len reaches full scale
   assign sat3  = (rlen >= ROOT_W'(FULL_SCALE));
   assign diff3 = rlen - ROOT_W'(dz_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= rv;
      end
      num3_ff  <= (zero3 || sat3) ? '0 :
                  NUM_W'(diff3[MAG_W-1:0]) * NUM_W'(FULL_SCALE);
      den3_ff  <= DEN_W'(FULL_SCALE - dz_eff);
      side3_ff <= {rside, rlen, zero3, sat3};
   end

   logic                mv;
   logic [QUO_W-1:0]    mquo;
   logic [M_SIDE_W-1:0] mside;

   srd_div #(.SIDE_W(M_SIDE_W)) u_div_mag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_num    (num3_ff),
      .in_den    (den3_ff),
      .in_side   (side3_ff),
      .out_valid (mv),
      .out_quo   (mquo),
      .out_side  (mside)
   );

   logic             m_sx, m_sy, m_zero, m_sat;
   logic [MAG_W-1:0] m_ax, m_ay;
   logic [ROOT_W-1:0] m_len;
   logic [MAG_W-1:0] mag;

   assign {m_sx, m_sy, m_ax, m_ay, m_len, m_zero, m_sat} = mside;
   assign mag = m_sat ? FULL_SCALE : mquo;

   // stage 4: axis times magnitude
   logic             v4_ff;
   logic [NUM_W-1:0] px4_ff, py4_ff;
   logic [DEN_W-1:0] len4_ff;
   logic             sx4_ff, sy4_ff, zero4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= mv;
      end
      px4_ff   <= NUM_W'(m_ax) * NUM_W'(mag);
      py4_ff   <= NUM_W'(m_ay) * NUM_W'(mag);
      len4_ff  <= m_len;
      sx4_ff   <= m_sx;
      sy4_ff   <= m_sy;
      zero4_ff <= m_zero;
   end

   logic             xv, yv;
   logic [QUO_W-1:0] qx, qy;
   logic [1:0]       xside;
   logic             yside;

   srd_div #(.SIDE_W(2)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_num    (px4_ff),
      .in_den    (len4_ff),
      .in_side   ({sx4_ff, zero4_ff}),
      .out_valid (xv),
      .out_quo   (qx),
      .out_side  (xside)
   );

   srd_div #(.SIDE_W(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_num    (py4_ff),
      .in_den    (len4_ff),
      .in_side   (sy4_ff),
      .out_valid (yv),
      .out_quo   (qy),
      .out_side  (yside)
   );

   // output word register
   logic              rsp_valid_ff;
   logic [AXIS_W-1:0] out_x_ff, out_y_ff;
   logic              in_dz_ff;
   logic [AXIS_W-1:0] ext_x, ext_y;

   assign ext_x = {1'b0, qx};
   assign ext_y = {1'b0, qy};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= xv && yv;
      end
      out_x_ff <= xside[0] ? '0 : (xside[1] ? -ext_x : ext_x);
      out_y_ff <= xside[0] ? '0 : (yside ? -ext_y : ext_y);
      in_dz_ff <= xside[0];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_in_deadzone = in_dz_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted sample produced no word at the expected latency");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_deadzone) |-> (rsp_out_x == '0 && rsp_out_y == '0))
      else $error("deadzone word carries a nonzero vector");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_x != 16'sh8000 && rsp_out_y != 16'sh8000))
      else $error("output component outside full scale");

endmodule

### tb/tb_stick_radial_deadzone.sv
// ---------------------------------------------------------------------------
// tb_stick_radial_deadzone
// Drives X/Y stick samples and deadzone settings into the radial deadzone
// block. Each accepted sample is scored against a local integer model.
// ---------------------------------------------------------------------------
module tb_stick_radial_deadzone;
   timeunit 1ns;
   timeprecision 1ps;
   import srd_pkg::*;

   localparam int LATENCY     = 51;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [AXIS_W-1:0] out_x;
      logic signed [AXIS_W-1:0] out_y;
      logic                     in_dz;
   } stick_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [AXIS_W-1:0] req_raw_x = '0;
   logic signed [AXIS_W-1:0] req_raw_y = '0;
   logic rsp_valid;
   logic signed [AXIS_W-1:0] rsp_out_x;
   logic signed [AXIS_W-1:0] rsp_out_y;
   logic rsp_in_deadzone;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [MAG_W-1:0] csr_stick_deadzone = '0;

   stick_word_type   expected_words[$];
   logic [MAG_W-1:0] deadzone_reg = DZ_RESET;
   int               error_count = 0;
   int               cycle_count = 0;
   int               idle_pct = 0;
   int               rand_idx = 0;

   stick_radial_deadzone uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned int_sqrt(int unsigned n);
      int unsigned root;
      int unsigned b;
      root = 0;
      b = 32'h4000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic logic signed [AXIS_W-1:0] steer_axis(int a, longint mag, longint len);
      longint q;
      q = ((a < 0 ? -a : a) * mag) / len;
      return AXIS_W'(a < 0 ? -q : q);
   endfunction

   function automatic stick_word_type condition_stick(logic signed [AXIS_W-1:0] rx,
                                                      logic signed [AXIS_W-1:0] ry);
      stick_word_type w;
      int             x, y;
      int unsigned    dz, len;
      longint         mag;
      x = (rx == -32768) ? -32767 : int'(rx);
      y = (ry == -32768) ? -32767 : int'(ry);
      dz = 32'((deadzone_reg > DZ_MAX) ? DZ_MAX : deadzone_reg);
      len = int_sqrt(x * x + y * y);
      if (len == 0 || len <= dz) begin
         w.out_x = '0;
         w.out_y = '0;
         w.in_dz = 1'b1;
      end else begin
         mag = (longint'(len - dz) * 32767) / (32767 - dz);
         if (mag > 32767) mag = 32767;
         w.out_x = steer_axis(x, mag, len);
         w.out_y = steer_axis(y, mag, len);
         w.in_dz = 1'b0;
      end
      return w;
   endfunction

   // result scoreboard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            error_count <= error_count + 1;
            if (error_count < 10) $display("unexpected result word");
         end else begin
            stick_word_type e;
            e = expected_words.pop_front();
            if (e.out_x !== rsp_out_x || e.out_y !== rsp_out_y
                || e.in_dz !== rsp_in_deadzone) begin
               error_count <= error_count + 1;
               if (error_count < 10)
                  $display("mismatch: exp %0d %0d %0b got %0d %0d %0b", e.out_x,
                           e.out_y, e.in_dz, rsp_out_x, rsp_out_y, rsp_in_deadzone);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // start stays high between back-to-back words; drain_pipe drops it
   task automatic send_sample(logic signed [AXIS_W-1:0] rx, logic signed [AXIS_W-1:0] ry);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_raw_x <= rx;
      req_raw_y <= ry;
      do @(posedge clock); while (busy);
      expected_words.push_back(condition_stick(rx, ry));
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      int n;
      n = 0;
      start <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      while (n < LATENCY + 4) begin
         @(negedge clock);
         n++;
      end
   endtask

   task automatic write_deadzone(logic [MAG_W-1:0] v);
      drain_pipe();
      csr_valid <= 1'b1;
      csr_stick_deadzone <= v;
      do @(posedge clock); while (!csr_ready);
      deadzone_reg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed();
      int dz_set[4] = '{0, 1, 31128, 32767};
      foreach (dz_set[i]) begin
         write_deadzone(MAG_W'(dz_set[i]));
         send_sample(16'sh0000, 16'sh0000);
         send_sample(16'sh8000, 16'sh8000);
         send_sample(16'sd32767, 16'sd32767);
         send_sample(16'sh8000, 16'sd0);
         send_sample(16'sd0, 16'sd32767);
         send_sample(16'sd1, -16'sd1);
      end
   endtask

   task automatic test_random(int count);
      logic signed [AXIS_W-1:0] rx, ry;
      int                       phase;
      for (int i = 0; i < count; i++) begin
         if (rand_idx % 100 == 0) begin
            phase = (rand_idx / 100) % 4;
            idle_pct = (phase == 1) ? 62 : ((phase == 3) ? 9 : 0);
         end
         rand_idx++;
         if ($urandom_range(3) == 0) begin
            rx = AXIS_W'(int'($urandom_range(6000)) - 3000);
            ry = AXIS_W'(int'($urandom_range(6000)) - 3000);
         end else begin
            rx = AXIS_W'($urandom);
            ry = AXIS_W'($urandom);
         end
         send_sample(rx, ry);
         if (i == count / 2) drain_pipe();
      end
      idle_pct = 0;
   endtask

   task automatic test_deadzone_sweep();
      write_deadzone(DZ_RESET);
      test_random(150);
      write_deadzone(MAG_W'($urandom_range(31128)));
      test_random(200);
      write_deadzone(MAG_W'($urandom_range(32767, 31129)));
      test_random(150);
      write_deadzone(15'd0);
      test_random(175);
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_random(20); // reset deadzone value
      test_directed();
      test_deadzone_sweep();
      drain_pipe();
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
